// File: rtl/pmq_pkg.sv
// pmq_pkg: shared types and constants for the partitioned multi-queue.
// No dependencies; imported by all files but pmq_channels, pmq_ram and pmq_fifo.
package pmq_pkg;

   // fixed by the item format
   localparam int unsigned QUEUE_SLOTS   = 4;   // reachable through a 2-bit queue index
   localparam int unsigned COUNT_BITS    = 3;   // width of the queue-count register
   localparam logic [2:0]  QUEUES_RESET  = 3'd4;
   localparam logic        CMD_ENQUEUE   = 1'b0;
   localparam logic        CMD_DEQUEUE   = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   // classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_BAD = 2'd2
   } op_type;

endpackage

// File: rtl/pmq_channels.sv
// pmq_channels: valid/ready channel interfaces of the partitioned multi-queue.
// Depends on nothing; used by the top level and its environment.
interface pmq_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic [1:0]         queue_index;
   logic signed [31:0] item_value;
   modport source (output valid, command, queue_index, item_value, input ready);
   modport sink   (input valid, command, queue_index, item_value, output ready);
endinterface

interface pmq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] read_value;
   modport source (output valid, status, read_value, input ready);
   modport sink   (input valid, status, read_value, output ready);
endinterface

interface pmq_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] queues_in_use;
   modport source (output valid, queues_in_use, input ready);
   modport sink   (input valid, queues_in_use, output ready);
endinterface

// File: rtl/partitioned_multi_queue.sv
// Usage
//   Several linear FIFO queues share one word store, split into equal partitions
//   (the last one takes the remainder). Channels:
//     req_chan : command (0 enqueue, 1 dequeue), queue_index, item_value.
//     rsp_chan : status (ok, overflow, underflow, bad index) and read_value,
//                exactly one result item per request item, in order.
//     csr_chan : writes queues_in_use; always ready. Every write empties all
//                queues. Write only while no request is in flight.
//   A request passes the two-entry queue and then the result register before
//   its result is offered.
//   Throughput: one item per cycle while results are taken; each item touches
//   one queue's pointers and one word of the single-port store, whose read is
//   registered. A two-entry queue lies between classifier and executing stage.
//   Reset: all queues empty, queues_in_use = 4, no result pending.
//   Receiver stall: the result register holds, the back stops, the two-entry
//   queue fills and req_chan.ready falls.
// Depends on pmq_pkg, pmq_channels, pmq_fifo, pmq_front and pmq_back.
module partitioned_multi_queue #(
   parameter int unsigned STORE_DEPTH = 32,
   parameter int unsigned QUEUE_LIMIT = 4,
   parameter int unsigned WORD_BITS   = 32
) (
   input  logic      clock,
   input  logic      reset,
   pmq_req_if.sink   req_chan,
   pmq_rsp_if.source rsp_chan,
   pmq_csr_if.sink   csr_chan
);
   import pmq_pkg::*;

   localparam int unsigned AW = $clog2(STORE_DEPTH);
   localparam int unsigned EW = 2 + 2 + 32 + AW + AW + 1;

   logic          push, pop, space_avail, op_valid, flush;
   op_type        f_op, b_op;
   logic [1:0]    f_queue, b_queue;
   logic [31:0]   f_item, b_item;
   logic [AW-1:0] f_start, b_start;
   logic [AW:0]   f_end, b_end;
   logic [EW-1:0] fifo_wdata, fifo_rdata;

   pmq_front #(
      .STORE_DEPTH (STORE_DEPTH),
      .QUEUE_LIMIT (QUEUE_LIMIT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_chan    (csr_chan),
      .space_avail (space_avail),
      .push        (push),
      .push_op     (f_op),
      .push_queue  (f_queue),
      .push_item   (f_item),
      .push_start  (f_start),
      .push_end    (f_end),
      .flush       (flush)
   );

   assign fifo_wdata = {f_op, f_queue, f_item, f_start, f_end};

   pmq_fifo #(
      .WIDTH (EW),
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (fifo_wdata),
      .not_full  (space_avail),
      .pop       (pop),
      .pop_data  (fifo_rdata),
      .not_empty (op_valid)
   );

   assign b_op    = op_type'(fifo_rdata[EW-1 -: 2]);
   assign b_queue = fifo_rdata[EW-3 -: 2];
   assign b_item  = fifo_rdata[EW-5 -: 32];
   assign b_start = fifo_rdata[2*AW : AW+1];
   assign b_end   = fifo_rdata[AW:0];

   pmq_back #(
      .STORE_DEPTH (STORE_DEPTH),
      .WORD_BITS   (WORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .flush    (flush),
      .op_valid (op_valid),
      .op_kind  (b_op),
      .op_queue (b_queue),
      .op_item  (b_item),
      .op_start (b_start),
      .op_end   (b_end),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: rtl/pmq_ram.sv
// pmq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// File: rtl/pmq_fifo.sv
// pmq_fifo: short item queue between the classifying front and the executing back.
// No dependencies.
module pmq_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             not_full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign not_full  = (count_ff != CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/pmq_front.sv
// pmq_front: queue-count register and request classifier (index check, partition bounds).
// Depends on pmq_pkg and pmq_channels.
module pmq_front #(
   parameter int unsigned STORE_DEPTH = 32,
   parameter int unsigned QUEUE_LIMIT = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   pmq_req_if.sink                         req_chan,
   pmq_csr_if.sink                         csr_chan,
   input  logic                            space_avail,
   output logic                            push,
   output pmq_pkg::op_type                 push_op,
   output logic [1:0]                      push_queue,
   output logic [31:0]                     push_item,
   output logic [$clog2(STORE_DEPTH)-1:0]  push_start,
   output logic [$clog2(STORE_DEPTH):0]    push_end,
   output logic                            flush
);
   import pmq_pkg::*;

   localparam int unsigned AW = $clog2(STORE_DEPTH);
   localparam int unsigned TAB_SIZE = 1 << COUNT_BITS;

   // per register code: effective queue count and partition size
   logic [COUNT_BITS-1:0] active_tab [TAB_SIZE];
   logic [AW:0]           size_tab   [TAB_SIZE];

   for (genvar v = 0; v < TAB_SIZE; v++) begin : g_tab
      localparam int unsigned NQ = (v == 0) ? 1 : ((v > QUEUE_LIMIT) ? QUEUE_LIMIT : v);
      localparam int unsigned SZ = STORE_DEPTH / NQ;
      assign active_tab[v] = COUNT_BITS'(NQ);
      assign size_tab[v]   = (AW + 1)'(SZ);
   end

   logic [COUNT_BITS-1:0] active_ff;
   logic [AW:0]           size_ff;
   logic [COUNT_BITS-1:0] q_ext, q_next;
   logic [AW+2:0]         start_prod;

   assign csr_chan.ready = 1'b1;
   assign flush          = csr_chan.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= active_tab[QUEUES_RESET];
         size_ff   <= size_tab[QUEUES_RESET];
      end else if (csr_chan.valid) begin
         active_ff <= active_tab[csr_chan.queues_in_use];
         size_ff   <= size_tab[csr_chan.queues_in_use];
      end
   end

   assign req_chan.ready = space_avail;
   assign push           = req_chan.valid && space_avail;

   assign q_ext      = COUNT_BITS'(req_chan.queue_index);
   assign q_next     = q_ext + COUNT_BITS'(1);
   assign start_prod = (AW + 3)'(size_ff) * (AW + 3)'(req_chan.queue_index);

   assign push_queue = req_chan.queue_index;
   assign push_item  = req_chan.item_value;
   assign push_start = start_prod[AW-1:0];
   // the last queue in use takes the remainder of the store
   assign push_end   = (q_next >= active_ff) ? (AW + 1)'(STORE_DEPTH)
                                             : start_prod[AW:0] + size_ff;

   always_comb begin
      if (q_ext >= active_ff) begin
         push_op = OP_BAD;
      end else if (req_chan.command == CMD_DEQUEUE) begin
         push_op = OP_DEQ;
      end else begin
         push_op = OP_ENQ;
      end
   end

endmodule

// File: rtl/pmq_back.sv
// pmq_back: per-queue pointers, word store and result register.
// Depends on pmq_pkg, pmq_channels and pmq_ram.
module pmq_back #(
   parameter int unsigned STORE_DEPTH = 32,
   parameter int unsigned WORD_BITS   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            flush,
   input  logic                            op_valid,
   input  pmq_pkg::op_type                 op_kind,
   input  logic [1:0]                      op_queue,
   input  logic [31:0]                     op_item,
   input  logic [$clog2(STORE_DEPTH)-1:0]  op_start,
   input  logic [$clog2(STORE_DEPTH):0]    op_end,
   output logic                            pop,
   pmq_rsp_if.source                       rsp_chan
);
   import pmq_pkg::*;

   localparam int unsigned AW = $clog2(STORE_DEPTH);

   logic [QUEUE_SLOTS-1:0] occ_ff, occ_in;
   logic [AW-1:0]          head_ff [QUEUE_SLOTS];
   logic [AW-1:0]          head_in [QUEUE_SLOTS];
   logic [AW-1:0]          tail_ff [QUEUE_SLOTS];
   logic [AW-1:0]          tail_in [QUEUE_SLOTS];

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic             from_ram_ff, from_ram_in;

   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_addr;
   logic [AW:0]      tail_inc;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

   assign pop       = op_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign tail_inc  = {1'b0, tail_ff[op_queue]} + (AW + 1)'(1);
   assign ram_wdata = WORD_BITS'(op_item);

   always_comb begin
      occ_in      = occ_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      status_in   = status_ff;
      from_ram_in = from_ram_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_addr    = head_ff[op_queue];
      if (pop) begin
         status_in   = ST_OK;
         from_ram_in = 1'b0;
         unique case (op_kind)
            OP_ENQ: begin
               if (!occ_ff[op_queue]) begin
                  if ({1'b0, op_start} >= op_end) begin
                     status_in = ST_OVERFLOW;   // zero-length partition
                  end else begin
                     occ_in[op_queue]  = 1'b1;
                     head_in[op_queue] = op_start;
                     tail_in[op_queue] = op_start;
                     ram_we            = 1'b1;
                     ram_addr          = op_start;
                  end
               end else if (tail_inc >= op_end) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  tail_in[op_queue] = tail_inc[AW-1:0];
                  ram_we            = 1'b1;
                  ram_addr          = tail_inc[AW-1:0];
               end
            end
            OP_DEQ: begin
               if (!occ_ff[op_queue]) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  ram_re      = 1'b1;
                  from_ram_in = 1'b1;
                  // the next enqueue re-seats head and tail at the partition start
                  if (head_ff[op_queue] == tail_ff[op_queue]) begin
                     occ_in[op_queue] = 1'b0;
                  end else begin
                     head_in[op_queue] = head_ff[op_queue] + AW'(1);
                  end
               end
            end
            default: begin
               status_in = ST_BAD_INDEX;
            end
         endcase
      end
      if (flush) begin
         occ_in = '0;
      end
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      status_ff   <= status_in;
      from_ram_ff <= from_ram_in;
   end

   pmq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_addr),
      .wr_data    (ram_wdata),
      .rd_en      (ram_re),
      .rd_addr    (ram_addr),
      .rd_data_ff (ram_rdata)
   );

   // read data holds while the result waits: no read is issued without a pop
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.read_value = from_ram_ff ? $signed(32'(ram_rdata))
                              : ((status_ff == ST_UNDERFLOW) ? -32'sd1 : 32'sd0);

endmodule

// File: rtl/pmq_checker.sv
// pmq_checker: port-level assertions for partitioned_multi_queue, bound to the top.
// Depends on pmq_pkg.
module pmq_port_props (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_read_value
);
   import pmq_pkg::*;

   // a result already offered stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_underflow_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_UNDERFLOW) |-> rsp_read_value == 32'hFFFF_FFFF)
      else $error("underflow result not all ones");

   a_no_data_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_OVERFLOW) || (rsp_status == ST_BAD_INDEX))
      |-> rsp_read_value == 32'd0)
      else $error("overflow or bad index result carries data");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind partitioned_multi_queue pmq_port_props u_pmq_port_props (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_read_value (rsp_chan.read_value)
);

// File: dv/pmq_checker.sv
`timescale 1ns / 1ps
// pmq_checker: passive predictor and scoreboard for the partitioned multi-queue.
// Watches the request, result and register channels; depends on pmq_pkg.
module pmq_checker #(
   parameter int unsigned STORE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_command,
   input  logic [1:0]  req_queue_index,
   input  logic [31:0] req_item_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_read_value,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_queues_in_use,
   output int          mismatch_count,
   output int          results_pending,
   output int          results_checked,
   output int          ok_seen,
   output int          overflow_seen,
   output int          underflow_seen,
   output int          bad_index_seen
);
   import pmq_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [31:0] value;
   } queue_result_type;

   localparam int REPORT_LIMIT = 10;

   logic [31:0]      word_store [STORE_DEPTH];
   int unsigned      head_pos [QUEUE_SLOTS];
   int unsigned      tail_pos [QUEUE_SLOTS];
   logic             occupied [QUEUE_SLOTS];
   logic [2:0]       queue_count;
   queue_result_type awaited_results [$];

   int mismatches = 0;
   int checked    = 0;
   int n_ok       = 0;
   int n_over     = 0;
   int n_under    = 0;
   int n_bad      = 0;

   // out-of-range counts are clamped, the raw value is kept
   function automatic int unsigned active_count();
      int unsigned n;
      n = queue_count;
      if (n < 1) n = 1;
      if (n > QUEUE_SLOTS) n = QUEUE_SLOTS;
      return n;
   endfunction

   function automatic int unsigned part_start(input int unsigned q);
      return (STORE_DEPTH / active_count()) * q;
   endfunction

   // one past the last word; the last partition takes the remainder
   function automatic int unsigned part_end(input int unsigned q);
      if (q + 1 >= active_count()) return STORE_DEPTH;
      return (STORE_DEPTH / active_count()) * (q + 1);
   endfunction

   task automatic clear_queues();
      for (int q = 0; q < QUEUE_SLOTS; q++) begin
         occupied[q] = 1'b0;
         head_pos[q] = (q < active_count()) ? part_start(q) : 0;
         tail_pos[q] = head_pos[q];
      end
   endtask

   function automatic queue_result_type run_queue_op(input logic cmd, input logic [1:0] qi,
                                                     input logic [31:0] val);
      queue_result_type res;
      int unsigned      q;
      int unsigned      start;
      int unsigned      stop;
      q          = qi;
      res.status = ST_OK;
      res.value  = '0;
      if (q >= active_count()) begin
         res.status = ST_BAD_INDEX;
      end else if (cmd == CMD_ENQUEUE) begin
         start = part_start(q);
         stop  = part_end(q);
         if (!occupied[q]) begin
            if (start >= stop) begin
               res.status = ST_OVERFLOW;
            end else begin
               head_pos[q] = start;
               tail_pos[q] = start;
               occupied[q] = 1'b1;
            end
         end else if (tail_pos[q] + 1 >= stop) begin
            // linear queue: freed words in front of the head are not reused
            res.status = ST_OVERFLOW;
         end else begin
            tail_pos[q]++;
         end
         if (res.status == ST_OK && tail_pos[q] < STORE_DEPTH) word_store[tail_pos[q]] = val;
      end else begin
         if (!occupied[q]) begin
            res.status = ST_UNDERFLOW;
            res.value  = '1;
         end else begin
            res.value = word_store[head_pos[q]];
            if (head_pos[q] == tail_pos[q]) begin
               occupied[q] = 1'b0;
               head_pos[q] = part_start(q);
               tail_pos[q] = head_pos[q];
            end else begin
               head_pos[q]++;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) word_store[i] = '0;
         queue_count = QUEUES_RESET;
         clear_queues();
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            queue_count = csr_queues_in_use;
            clear_queues();
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result with nothing awaited: status %0d value %h",
                           $realtime, rsp_status, rsp_read_value);
            end else begin
               want = awaited_results.pop_front();
               checked++;
               if (rsp_status !== want.status || rsp_read_value !== want.value) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"%0t: result %0d wrong: status exp %0d got %0d, ",
                               "value exp %h got %h"},
                              $realtime, checked, want.status, rsp_status, want.value,
                              rsp_read_value);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = run_queue_op(req_command, req_queue_index, req_item_value);
            unique case (want.status)
               ST_OK:        n_ok++;
               ST_OVERFLOW:  n_over++;
               ST_UNDERFLOW: n_under++;
               default:      n_bad++;
            endcase
            awaited_results.push_back(want);
         end
      end
      mismatch_count  <= mismatches;
      results_pending <= awaited_results.size();
      results_checked <= checked;
      ok_seen         <= n_ok;
      overflow_seen   <= n_over;
      underflow_seen  <= n_under;
      bad_index_seen  <= n_bad;
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// tb: top of the partitioned multi-queue testbench; makes stimulus and the verdict.
// Depends on pmq_pkg, pmq_channels, partitioned_multi_queue and pmq_checker.
module tb;
   import pmq_pkg::*;

   localparam int STORE_DEPTH     = 32;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int DRAIN_CYCLES    = 4;
   localparam int HOLD_CYCLES     = 80;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int NUM_PHASES      = 9;

   logic clock = 1'b0;
   logic reset;

   pmq_req_if req_bus ();
   pmq_rsp_if rsp_bus ();
   pmq_csr_if csr_bus ();

   int mismatch_count;
   int results_pending;
   int results_checked;
   int ok_seen;
   int overflow_seen;
   int underflow_seen;
   int bad_index_seen;

   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   int holds_asked    = 0;
   int holds_done     = 0;
   int idle_cycles    = 0;
   int items_sent     = 0;
   int settings_used  = 0;

   partitioned_multi_queue #(.STORE_DEPTH(STORE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   pmq_checker #(.STORE_DEPTH(STORE_DEPTH)) checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_command       (req_bus.command),
      .req_queue_index   (req_bus.queue_index),
      .req_item_value    (req_bus.item_value),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_status        (rsp_bus.status),
      .rsp_read_value    (rsp_bus.read_value),
      .csr_valid         (csr_bus.valid),
      .csr_ready         (csr_bus.ready),
      .csr_queues_in_use (csr_bus.queues_in_use),
      .mismatch_count    (mismatch_count),
      .results_pending   (results_pending),
      .results_checked   (results_checked),
      .ok_seen           (ok_seen),
      .overflow_seen     (overflow_seen),
      .underflow_seen    (underflow_seen),
      .bad_index_seen    (bad_index_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random back-pressure, plus long hold-offs on request
   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done != holds_asked) begin
            holds_done++;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= !receiver_idles || ($urandom_range(99) >= 32);
            @(posedge clock);
         end
      end
   end

   // counts cycles in which no channel moves an item
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_req(input logic cmd, input logic [1:0] qi, input logic [31:0] val);
      while (sender_idles && $urandom_range(99) < 32) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.queue_index <= qi;
      req_bus.item_value  <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_queue_count(input logic [2:0] count);
      csr_bus.valid         <= 1'b1;
      csr_bus.queues_in_use <= count;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // register writes only happen once every result is back
   task automatic settle_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly fill-then-drain bursts on one queue, some bad indexes, some loose ops
   task automatic run_phase(input logic [2:0] count, input int unsigned enq_bias);
      int unsigned n;
      int unsigned part;
      int unsigned span;
      int unsigned q;
      int unsigned len;
      int unsigned r;
      int unsigned sent;
      n    = (count == 0) ? 1 : (count > QUEUE_SLOTS) ? QUEUE_SLOTS : count;
      part = STORE_DEPTH / n;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
         r = $urandom_range(99);
         if (r < 50) begin
            q    = $urandom_range(n - 1);
            span = (q == n - 1) ? STORE_DEPTH - part * (n - 1) : part;
            len  = $urandom_range(span + 1, 1);
            repeat (len) send_req(CMD_ENQUEUE, 2'(q), $urandom());
            repeat (len + 1) send_req(CMD_DEQUEUE, 2'(q), $urandom());
            sent += 2 * len + 1;
         end else if (r < 60) begin
            q = (n < QUEUE_SLOTS) ? $urandom_range(QUEUE_SLOTS - 1, n)
                                  : $urandom_range(QUEUE_SLOTS - 1);
            send_req(1'($urandom_range(1)), 2'(q), $urandom());
            sent++;
         end else begin
            q = $urandom_range(n - 1);
            send_req(($urandom_range(99) < enq_bias) ? CMD_ENQUEUE : CMD_DEQUEUE, 2'(q),
                     $urandom());
            sent++;
         end
      end
   endtask

   logic [2:0]  phase_count [NUM_PHASES] = '{3'd1, 3'd4, 3'd3, 3'd2, 3'd0, 3'd7, 3'd5,
                                            3'd6, 3'd4};
   int unsigned phase_bias  [NUM_PHASES] = '{60, 50, 70, 40, 55, 65, 50, 45, 60};

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.command       = CMD_ENQUEUE;
      req_bus.queue_index   = '0;
      req_bus.item_value    = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.queues_in_use = QUEUES_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: fill queue 0 to its partition end, then the linear overflow
      write_queue_count(3'd4);
      send_req(CMD_ENQUEUE, 2'd0, 32'h8000_0000);
      send_req(CMD_ENQUEUE, 2'd0, 32'h7fff_ffff);
      send_req(CMD_ENQUEUE, 2'd0, 32'hffff_ffff);
      send_req(CMD_ENQUEUE, 2'd0, 32'h0000_0000);
      send_req(CMD_ENQUEUE, 2'd0, 32'h0000_0001);
      send_req(CMD_ENQUEUE, 2'd0, 32'ha5a5_a5a5);
      send_req(CMD_ENQUEUE, 2'd0, 32'h5a5a_5a5a);
      send_req(CMD_ENQUEUE, 2'd0, 32'hffff_fffe);
      send_req(CMD_ENQUEUE, 2'd0, 32'h1234_5678);
      send_req(CMD_DEQUEUE, 2'd0, 32'hffff_ffff);
      send_req(CMD_ENQUEUE, 2'd0, 32'h8765_4321);
      send_req(CMD_DEQUEUE, 2'd1, 32'h0000_0000);
      send_req(CMD_ENQUEUE, 2'd3, 32'h7fff_ffff);
      send_req(CMD_DEQUEUE, 2'd3, 32'h0000_0000);
      send_req(CMD_DEQUEUE, 2'd3, 32'h0000_0000);
      settle_results();
      write_queue_count(3'd2);
      send_req(CMD_ENQUEUE, 2'd2, 32'hdead_beef);
      send_req(CMD_DEQUEUE, 2'd3, 32'h0000_0000);
      settle_results();
      // a count of zero acts as one queue over the whole store
      write_queue_count(3'd0);
      send_req(CMD_ENQUEUE, 2'd1, 32'h0bad_0bad);
      send_req(CMD_ENQUEUE, 2'd0, 32'h8000_0001);
      send_req(CMD_DEQUEUE, 2'd0, 32'h0000_0000);
      send_req(CMD_DEQUEUE, 2'd0, 32'h0000_0000);
      settle_results();
      write_queue_count(3'd7);
      send_req(CMD_ENQUEUE, 2'd3, 32'hc0de_cafe);
      send_req(CMD_DEQUEUE, 2'd3, 32'h0000_0000);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle_results();
         write_queue_count(phase_count[p]);
         if (p == 2) holds_asked <= holds_asked + 1;
         sender_idles   = (p != 4 && p != 5);
         receiver_idles = (p != 4 && p != 5);
         run_phase(phase_count[p], phase_bias[p]);
      end
      settle_results();

      $display("Run: %0d request items over %0d queue-count settings incl. 0 and 5..7",
               items_sent, settings_used);
      $display("Results checked: %0d (ok %0d, overflow %0d, underflow %0d, bad index %0d)",
               results_checked, ok_seen, overflow_seen, underflow_seen, bad_index_seen);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
